### hw/rtl/hee_pkg.sv
// Shared types, constants and operation codes of the Hermite easing evaluator.
package hee_pkg;

  localparam int TIME_WIDTH_DEF    = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TANGENT_FRACTION  = 12;
  localparam int TOTAL_WIDTH       = 48;
  localparam int ADDR_WIDTH        = 5;
  localparam int DATA_WIDTH        = 32;
  localparam int VALUE_WIDTH       = 32;

  localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [2:0] REG_SAMPLE_COUNT    = 3'd1;
  localparam logic [2:0] REG_START_VALUE     = 3'd2;
  localparam logic [2:0] REG_END_VALUE       = 3'd3;
  localparam logic [2:0] REG_START_TANGENT   = 3'd4;
  localparam logic [2:0] REG_END_TANGENT     = 3'd5;

  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_TOTAL   = 4'd1;
  localparam logic [3:0] OP_DIVINIT = 4'd2;
  localparam logic [3:0] OP_DIVSTEP = 4'd3;
  localparam logic [3:0] OP_SQ      = 4'd4;
  localparam logic [3:0] OP_CUBE    = 4'd5;
  localparam logic [3:0] OP_BASIS   = 4'd6;
  localparam logic [3:0] OP_TAN0    = 4'd7;
  localparam logic [3:0] OP_TAN1    = 4'd8;
  localparam logic [3:0] OP_Y       = 4'd9;
  localparam logic [3:0] OP_YDIFF   = 4'd10;
  localparam logic [3:0] OP_OUT     = 4'd11;

  typedef struct packed {
    logic [31:0]        sample_interval;
    logic [15:0]        sample_count;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
    logic signed [15:0] start_tangent;
    logic signed [15:0] end_tangent;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       first;
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
  } dp_status_t;

endpackage

### hw/rtl/hee_regs.sv
// APB configuration register file of the Hermite easing evaluator.
module hee_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hee_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [hee_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [hee_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                             pready,
  output hee_pkg::cfg_t                    cfg
);

  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval <= 32'd1;
      cfg.sample_count    <= 16'd1;
      cfg.start_value     <= '0;
      cfg.end_value       <= '0;
      cfg.start_tangent   <= '0;
      cfg.end_tangent     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        hee_pkg::REG_SAMPLE_INTERVAL: cfg.sample_interval <= pwdata;
        hee_pkg::REG_SAMPLE_COUNT:    cfg.sample_count    <= pwdata[15:0];
        hee_pkg::REG_START_VALUE:     cfg.start_value     <= $signed(pwdata);
        hee_pkg::REG_END_VALUE:       cfg.end_value       <= $signed(pwdata);
        hee_pkg::REG_START_TANGENT:   cfg.start_tangent   <= $signed(pwdata[15:0]);
        hee_pkg::REG_END_TANGENT:     cfg.end_tangent     <= $signed(pwdata[15:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      hee_pkg::REG_SAMPLE_INTERVAL: prdata = cfg.sample_interval;
      hee_pkg::REG_SAMPLE_COUNT:    prdata = {16'd0, cfg.sample_count};
      hee_pkg::REG_START_VALUE:     prdata = cfg.start_value;
      hee_pkg::REG_END_VALUE:       prdata = cfg.end_value;
      hee_pkg::REG_START_TANGENT:   prdata = {16'd0, cfg.start_tangent};
      hee_pkg::REG_END_TANGENT:     prdata = {16'd0, cfg.end_tangent};
      default:                      prdata = '0;
    endcase
  end

endmodule

### hw/rtl/hee_datapath.sv
// Datapath: elapsed time, bit-serial divider, shared multiplier and Hermite basis.
module hee_datapath #(
  parameter int TIME_WIDTH    = hee_pkg::TIME_WIDTH_DEF,
  parameter int FRACTION_BITS = hee_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  hee_pkg::cfg_t                      cfg,
  input  logic [TIME_WIDTH-1:0]              ts,
  input  hee_pkg::dp_cmd_t                   cmd,
  output hee_pkg::dp_status_t                status,
  output logic [hee_pkg::VALUE_WIDTH-1:0]    value
);

  localparam int F   = FRACTION_BITS;
  localparam int TOW = hee_pkg::TOTAL_WIDTH;
  localparam int AW  = F + 4;
  localparam int BW  = 34;
  localparam int PW  = AW + BW;
  localparam int CW  = ((TIME_WIDTH > TOW) ? TIME_WIDTH : TOW) + 1;
  localparam int VW  = PW - F + 1;
  localparam int TF  = hee_pkg::TANGENT_FRACTION;

  logic [TIME_WIDTH-1:0] start_time;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [TOW-1:0]        total;
  logic [CW-1:0]         rem;
  logic [F-1:0]          q;
  logic                  t_zero;
  logic                  t_full;
  logic signed [AW-1:0]  t_reg;
  logic signed [AW-1:0]  t2;
  logic signed [AW-1:0]  h01;
  logic signed [AW-1:0]  h10;
  logic signed [AW-1:0]  h11;
  logic signed [AW-1:0]  y;
  logic signed [PW-1:0]  acc;
  logic signed [PW-1:0]  prod;

  logic [CW-1:0]         elapsed_ext;
  logic [CW-1:0]         total_ext;
  logic [CW-1:0]         rem_sh;
  logic                  ge;
  logic signed [AW-1:0]  t_cur;
  logic signed [AW-1:0]  prod_shift;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [PW-1:0]  tan_sum;
  logic signed [32:0]    diff;
  logic signed [VW-1:0]  vsum;
  logic [31:0]           sat;

  assign elapsed_ext   = {{(CW-TIME_WIDTH){1'b0}}, elapsed};
  assign total_ext     = {{(CW-TOW){1'b0}}, total};
  assign status.over   = elapsed_ext > total_ext;
  assign rem_sh        = {rem[CW-2:0], 1'b0};
  assign ge            = rem_sh >= total_ext;

  // A zero duration gives t = 0; elapsed reaching the duration gives exactly one.
  always_comb begin
    if (t_zero) begin
      t_cur = '0;
    end else if (t_full) begin
      t_cur = {{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    end else begin
      t_cur = {{(AW-F){1'b0}}, q};
    end
  end

  assign prod_shift = $signed(prod[F +: AW]);
  assign tan_sum    = acc + prod;
  assign diff       = {cfg.end_value[31], cfg.end_value} - {cfg.start_value[31], cfg.start_value};

  always_comb begin
    case (cmd.op)
      hee_pkg::OP_SQ: begin
        mul_a = t_cur;
        mul_b = {{(BW-AW){t_cur[AW-1]}}, t_cur};
      end
      hee_pkg::OP_CUBE: begin
        mul_a = prod_shift;
        mul_b = {{(BW-AW){t_reg[AW-1]}}, t_reg};
      end
      hee_pkg::OP_TAN0: begin
        mul_a = h10;
        mul_b = {{(BW-16){cfg.start_tangent[15]}}, cfg.start_tangent};
      end
      hee_pkg::OP_TAN1: begin
        mul_a = h11;
        mul_b = {{(BW-16){cfg.end_tangent[15]}}, cfg.end_tangent};
      end
      default: begin
        mul_a = y;
        mul_b = {diff[32], diff};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign vsum = {{(VW-32){cfg.start_value[31]}}, cfg.start_value}
              + {prod[PW-1], prod[PW-1:F]};

  always_comb begin
    if ((&vsum[VW-1:31]) || !(|vsum[VW-1:31])) begin
      sat = vsum[31:0];
    end else if (vsum[VW-1]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.first) begin
        start_time <= ts;
        elapsed    <= '0;
      end else begin
        elapsed <= ts - start_time;
      end
    end
    unique case (cmd.op)
      hee_pkg::OP_NONE: ;
      hee_pkg::OP_TOTAL: total <= cfg.sample_interval * cfg.sample_count;
      hee_pkg::OP_DIVINIT: begin
        rem    <= elapsed_ext;
        q      <= '0;
        t_zero <= (total == '0);
        t_full <= elapsed_ext >= total_ext;
      end
      hee_pkg::OP_DIVSTEP: begin
        rem <= ge ? (rem_sh - total_ext) : rem_sh;
        q   <= {q[F-2:0], ge};
      end
      hee_pkg::OP_SQ: begin
        t_reg <= t_cur;
        prod  <= mul_p;
      end
      hee_pkg::OP_CUBE: begin
        t2   <= prod_shift;
        prod <= mul_p;
      end
      hee_pkg::OP_BASIS: begin
        // prod_shift holds t^3 here.
        h01 <= AW'(3 * t2 - 2 * prod_shift);
        h10 <= AW'(t_reg - 2 * t2 + prod_shift);
        h11 <= prod_shift - t2;
      end
      hee_pkg::OP_TAN0: prod <= mul_p;
      hee_pkg::OP_TAN1: begin
        acc  <= prod;
        prod <= mul_p;
      end
      hee_pkg::OP_Y:     y     <= h01 + $signed(tan_sum[TF +: AW]);
      hee_pkg::OP_YDIFF: prod  <= mul_p;
      hee_pkg::OP_OUT:   value <= sat;
      default: ;
    endcase
  end

endmodule

### hw/rtl/hee_ctrl.sv
// Controller: sequences one request through the datapath and owns the stream handshakes.
module hee_ctrl #(
  parameter int FRACTION_BITS = hee_pkg::FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  hee_pkg::dp_status_t  status,
  output hee_pkg::dp_cmd_t     cmd
);

  localparam int CNT_W = $clog2(FRACTION_BITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TOTAL = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_CUBE  = 4'd5;
  localparam logic [3:0] S_BASIS = 4'd6;
  localparam logic [3:0] S_TAN0  = 4'd7;
  localparam logic [3:0] S_TAN1  = 4'd8;
  localparam logic [3:0] S_Y     = 4'd9;
  localparam logic [3:0] S_YDIFF = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic             started;
  logic             finished;
  logic             in_fire;
  logic             out_free;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.first  = !started;
    cmd.op     = hee_pkg::OP_NONE;
    unique case (state)
      S_IDLE: begin
        // Once finished, requests are taken and dropped.
        if (in_fire && !finished) begin
          cmd.load   = 1'b1;
          state_next = S_TOTAL;
        end
      end
      S_TOTAL: begin
        cmd.op     = hee_pkg::OP_TOTAL;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op     = hee_pkg::OP_DIVINIT;
        state_next = status.over ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        cmd.op = hee_pkg::OP_DIVSTEP;
        if (cnt == CNT_W'(FRACTION_BITS - 1)) begin
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op     = hee_pkg::OP_SQ;
        state_next = S_CUBE;
      end
      S_CUBE: begin
        cmd.op     = hee_pkg::OP_CUBE;
        state_next = S_BASIS;
      end
      S_BASIS: begin
        cmd.op     = hee_pkg::OP_BASIS;
        state_next = S_TAN0;
      end
      S_TAN0: begin
        cmd.op     = hee_pkg::OP_TAN0;
        state_next = S_TAN1;
      end
      S_TAN1: begin
        cmd.op     = hee_pkg::OP_TAN1;
        state_next = S_Y;
      end
      S_Y: begin
        cmd.op     = hee_pkg::OP_Y;
        state_next = S_YDIFF;
      end
      S_YDIFF: begin
        cmd.op     = hee_pkg::OP_YDIFF;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = hee_pkg::OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      started   <= 1'b0;
      finished  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        started <= 1'b1;
      end
      if (state == S_CHECK && status.over) begin
        finished <= 1'b1;
      end
      if (state == S_DIV) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (cmd.op == hee_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/hermite_easing_evaluator_unit.sv
// Top level of the Hermite easing evaluator.
// Each timestamp request on the input stream produces at most one eased value on the output
// stream; the first timestamp after reset sets the start time, and once the elapsed time
// exceeds sample_interval*sample_count the block drops every further request without a
// result until reset. A request that yields a value passes in order through the accept state,
// the duration product and range check, the bit-serial restoring divider that forms t, the
// square, cube, basis, two tangent, y and difference steps of the single shared multiplier and
// basis adders, and the output register load, which waits until an earlier result is taken.
// A request that ends the animation returns to idle after the range check. The next request
// is taken while a result still waits in the output register; configuration is to be written
// through the APB port while idle, which the block itself does not enforce.
module hermite_easing_evaluator_unit #(
  parameter int TIME_WIDTH    = hee_pkg::TIME_WIDTH_DEF,
  parameter int FRACTION_BITS = hee_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: timestamp[TIME_WIDTH-1:0], zero padding to a whole byte.
  input  logic [((TIME_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: value[31:0].
  output logic [hee_pkg::VALUE_WIDTH-1:0]      m_axis_tdata,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hee_pkg::ADDR_WIDTH-1:0]       paddr,
  input  logic [hee_pkg::DATA_WIDTH-1:0]       pwdata,
  output logic [hee_pkg::DATA_WIDTH-1:0]       prdata,
  output logic                                 pready
);

  hee_pkg::cfg_t       cfg;
  hee_pkg::dp_cmd_t    cmd;
  hee_pkg::dp_status_t status;

  hee_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hee_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  hee_datapath #(
    .TIME_WIDTH    (TIME_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk    (clk),
    .cfg    (cfg),
    .ts     (s_axis_tdata[TIME_WIDTH-1:0]),
    .cmd    (cmd),
    .status (status),
    .value  (m_axis_tdata)
  );

endmodule

### hw/rtl/hee_checker.sv
// Port-level assertions of the Hermite easing evaluator, bound to the top level.
module hee_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [hee_pkg::VALUE_WIDTH-1:0]   m_axis_tdata,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [hee_pkg::ADDR_WIDTH-1:0]    paddr,
  input logic [hee_pkg::DATA_WIDTH-1:0]    pwdata,
  input logic [hee_pkg::DATA_WIDTH-1:0]    prdata,
  input logic                              pready
);

  // A result waiting on the output is neither withdrawn nor changed.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed while stalled");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

  // A write to start_value reads back on the next cycle at the same address.
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[4:2] == hee_pkg::REG_START_VALUE)
    |=> (paddr != $past(paddr)) || (prdata == $past(pwdata)))
    else $error("configuration readback mismatch");

endmodule

bind hermite_easing_evaluator_unit hee_checker u_hee_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
